// File: rtl/vpr_pkg.sv
package vpr_pkg;

    // Default angle and trig widths
    localparam int PHASE_BITS_DEF = 24;
    localparam int TRIG_BITS_DEF  = 18;

    // round(2^56 / c), c = 299792458 m/s
    localparam logic [27:0] RECIP_C = 28'd240358262;

    // pi/2 in Q1.30, rounded
    localparam logic [30:0] PIHALF_Q30 = 31'h6487ED51;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_FREQ  = 2'd0,
        REG_OFF_L = 2'd1,
        REG_OFF_M = 2'd2,
        REG_OFF_N = 2'd3
    } t_reg_idx;

    // Quadrant of the phase angle
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Data that rides along with the phase math
    typedef struct packed {
        t_quad              quad;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               last;
    } t_side;

    // Taylor series divisors and floor(2^33 / d) reciprocals
    localparam logic [7:0]  SIN_DIV [0:6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
    localparam logic [32:0] SIN_RCP [0:6] = '{
        33'd1431655765, 33'd429496729, 33'd204522252, 33'd119304647,
        33'd78090314, 33'd55063683, 33'd40904450
    };
    localparam logic [7:0]  COS_DIV [0:7] = '{
        8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182, 8'd240
    };
    localparam logic [32:0] COS_RCP [0:7] = '{
        33'd4294967296, 33'd715827882, 33'd286331153, 33'd153391689,
        33'd95443717, 33'd65075262, 33'd47197442, 33'd35791394
    };

    // Clamp a series sum to [0, 1.0] in Q1.30
    function automatic logic [30:0] clamp_q30(input logic signed [35:0] v);
        logic [30:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 36'sd1073741824) begin
            r = 31'd1073741824;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/vpr_sincos.sv
module vpr_sincos (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [30:0]    i_x,
    input  vpr_pkg::t_side i_side,
    output logic           o_valid,
    output logic [30:0]    o_sin,
    output logic [30:0]    o_cos,
    output vpr_pkg::t_side o_side
);
    import vpr_pkg::*;

    localparam int STEPS = 8;

    logic [32:0]        r_ts [0:STEPS-1];
    logic [32:0]        r_tc [0:STEPS];
    logic signed [35:0] r_as [0:STEPS];
    logic signed [35:0] r_ac [0:STEPS];
    logic [31:0]        r_x2 [0:STEPS-1];
    t_side              r_sd [0:STEPS];
    logic               r_v  [0:STEPS];

    logic [61:0] xx;
    assign xx = 62'(i_x) * 62'(i_x);

    // Square the angle and seed the series
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2[0] <= xx[61:30];
            r_ts[0] <= 33'(i_x);
            r_tc[0] <= 33'(1) << 30;
            r_as[0] <= '0;
            r_ac[0] <= '0;
            r_sd[0] <= i_side;
        end
    end

    // One series term per three stages: add and multiply by x^2, then divide over two
    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam bit ADD = (j % 2 == 0);

        logic signed [35:0] r_a_as, r_a_ac, r_b_as, r_b_ac;
        logic [64:0]        r_a_pc;
        logic [32:0]        r_b_yc;
        logic [65:0]        r_b_mc;
        t_side              r_a_sd, r_b_sd;
        logic               r_a_v, r_b_v;
        logic signed [35:0] n_a_as, n_a_ac;
        logic [32:0]        q_c, rem_c;

        always_comb begin
            n_a_as = ADD ? r_as[j] + $signed({3'b000, r_ts[j]})
                         : r_as[j] - $signed({3'b000, r_ts[j]});
            n_a_ac = ADD ? r_ac[j] + $signed({3'b000, r_tc[j]})
                         : r_ac[j] - $signed({3'b000, r_tc[j]});
            q_c    = r_b_mc[65:33];
            rem_c  = r_b_yc - 33'(q_c * 33'(COS_DIV[j]));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v    <= 1'b0;
                r_b_v    <= 1'b0;
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_a_v    <= r_v[j];
                r_b_v    <= r_a_v;
                r_v[j+1] <= r_b_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_as    <= n_a_as;
                r_a_ac    <= n_a_ac;
                r_a_pc    <= 65'(r_tc[j]) * 65'(r_x2[j]);
                r_a_sd    <= r_sd[j];
                r_b_as    <= r_a_as;
                r_b_ac    <= r_a_ac;
                r_b_yc    <= r_a_pc[62:30];
                r_b_mc    <= 66'(r_a_pc[62:30]) * 66'(COS_RCP[j]);
                r_b_sd    <= r_a_sd;
                r_as[j+1] <= r_b_as;
                r_ac[j+1] <= r_b_ac;
                r_tc[j+1] <= (rem_c >= 33'(COS_DIV[j])) ? q_c + 33'd1 : q_c;
                r_sd[j+1] <= r_b_sd;
            end
        end

        // Sine needs its next term only before its last addition
        if (j < STEPS - 1) begin : g_sdiv
            logic [64:0] r_a_ps;
            logic [32:0] r_b_ys;
            logic [65:0] r_b_ms;
            logic [31:0] r_a_x2, r_b_x2;
            logic [32:0] q_s, rem_s;

            always_comb begin
                q_s   = r_b_ms[65:33];
                rem_s = r_b_ys - 33'(q_s * 33'(SIN_DIV[j]));
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a_ps    <= 65'(r_ts[j]) * 65'(r_x2[j]);
                    r_a_x2    <= r_x2[j];
                    r_b_ys    <= r_a_ps[62:30];
                    r_b_ms    <= 66'(r_a_ps[62:30]) * 66'(SIN_RCP[j]);
                    r_b_x2    <= r_a_x2;
                    r_ts[j+1] <= (rem_s >= 33'(SIN_DIV[j])) ? q_s + 33'd1 : q_s;
                    r_x2[j+1] <= r_b_x2;
                end
            end
        end
    end

    // Add the last cosine term and clamp both sums
    logic signed [35:0] cos_sum;
    assign cos_sum = r_ac[STEPS] + $signed({3'b000, r_tc[STEPS]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin  <= clamp_q30(r_as[STEPS]);
            o_cos  <= clamp_q30(cos_sum);
            o_side <= r_sd[STEPS];
        end
    end

endmodule

// File: rtl/visibility_phase_rotation_top.sv
// Visibility phase rotation.
// Input channel (i_valid / o_stall) takes one visibility word: baseline
// u, v, w in Q24.8 metres, amplitude re/im and an end flag. Output channel
// (o_valid / i_stall) gives the rotated amplitude, rounded and saturated to
// 32 bits, with the end flag copied.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// freq_hz, offset_l, offset_m, offset_n at indexes 0..3; write only while
// the block is empty.
// One word enters every cycle while the output is not stalled. The depth is
// set by the Taylor sine/cosine unit, which spends three stages (add and
// multiply by x^2, reciprocal multiply, quotient correction) on each of eight terms.
// A stalled output word holds the whole pipeline, and o_stall follows at
// once, so nothing is dropped or repeated; empty stages keep filling while
// the output is idle.
// Synchronous reset clears all valid bits and config registers to zero; the
// inverse wavelength follows reset or a new freq via r_fp_lo/hi, then r_inv.
module visibility_phase_rotation_top #(
    parameter int PHASE_BITS = vpr_pkg::PHASE_BITS_DEF,
    parameter int TRIG_BITS  = vpr_pkg::TRIG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_base_u,
    input  logic signed [31:0] i_base_v,
    input  logic signed [31:0] i_base_w,
    input  logic signed [31:0] i_amp_re,
    input  logic signed [31:0] i_amp_im,
    input  logic               i_end_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_rot_re,
    output logic signed [31:0] o_rot_im,
    output logic               o_end_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [34:0]        i_cfg_data
);
    import vpr_pkg::*;

    localparam int XPW = PHASE_BITS - 2 + 31;
    localparam int SH  = 31 - TRIG_BITS;
    localparam int PW  = 32 + TRIG_BITS;
    localparam logic [TRIG_BITS-1:0] TRIG_MAX = {1'b0, {(TRIG_BITS-1){1'b1}}};

    logic en;
    assign en          = !(o_valid && i_stall);
    assign o_stall     = o_valid && i_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    logic [34:0]        r_freq;
    logic signed [31:0] r_off_l, r_off_m, r_off_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= '0;
            r_off_l <= '0;
            r_off_m <= '0;
            r_off_n <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FREQ:  r_freq  <= i_cfg_data;
                REG_OFF_L: r_off_l <= i_cfg_data[31:0];
                REG_OFF_M: r_off_m <= i_cfg_data[31:0];
                REG_OFF_N: r_off_n <= i_cfg_data[31:0];
                default:   r_freq  <= r_freq;
            endcase
        end
    end

    // Inverse wavelength, Q7.32 per metre, free running
    logic [45:0] r_fp_lo;
    logic [44:0] r_fp_hi;
    logic [38:0] r_inv;
    logic [62:0] fp_sum;

    assign fp_sum = 63'(r_fp_lo) + (63'(r_fp_hi) << 18) + (63'(1) << 23);

    always_ff @(posedge i_clk) begin
        r_fp_lo <= 46'(r_freq[17:0]) * 46'(RECIP_C);
        r_fp_hi <= 45'(r_freq[34:18]) * 45'(RECIP_C);
        r_inv   <= fp_sum[62:24];
    end

    // Valid bits of the front stages
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    // Front stages: path sum, phase, angle
    logic signed [31:0]  r1_u, r1_vv, r1_w;
    t_side               r1_sd, r2_sd, r3_sd, r4_sd, r5_sd, r6_sd, r7_sd, r8_sd;
    logic signed [63:0]  r2_pl, r2_pm, r2_pn;
    logic signed [65:0]  r3_s;
    logic [43:0]         r4_pp00, r4_pp01;
    logic [42:0]         r4_pp10;
    logic [21:0]         r4_pp02;
    logic [25:0]         r4_pp11;
    logic [1:0]          r4_pp12;
    logic [69:0]         r5_ta, r5_tb;
    logic [PHASE_BITS-1:0] r6_phase;
    logic [XPW-1:0]      r7_xp;
    logic [30:0]         r8_x;

    logic [69:0]    se, n_ta, n_tb, n_t;
    logic [XPW-1:0] n_xr;
    t_side          in_sd, n7_sd;

    always_comb begin
        in_sd      = '0;
        in_sd.re   = i_amp_re;
        in_sd.im   = i_amp_im;
        in_sd.last = i_end_in;
        se   = 70'(r3_s);
        n_ta = 70'(r4_pp00) + (70'(r4_pp01) << 24) + (70'(r4_pp10) << 20);
        n_tb = (70'(r4_pp02) << 48) + (70'(r4_pp11) << 44) + (70'(r4_pp12) << 68);
        n_t  = r5_ta + r5_tb + (70'(1) << (69 - PHASE_BITS));
        n_xr = r7_xp + (XPW'(1) << (PHASE_BITS - 3));
        n7_sd      = r6_sd;
        n7_sd.quad = t_quad'(r6_phase[PHASE_BITS-1 -: 2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_u     <= i_base_u;
            r1_vv    <= i_base_v;
            r1_w     <= i_base_w;
            r1_sd    <= in_sd;
            r2_pl    <= 64'(r1_u) * 64'(r_off_l);
            r2_pm    <= 64'(r1_vv) * 64'(r_off_m);
            r2_pn    <= 64'(r1_w) * 64'(r_off_n);
            r2_sd    <= r1_sd;
            r3_s     <= 66'(r2_pl) + 66'(r2_pm) + 66'(r2_pn);
            r3_sd    <= r2_sd;
            r4_pp00  <= 44'(r_inv[19:0]) * 44'(se[23:0]);
            r4_pp01  <= 44'(r_inv[19:0]) * 44'(se[47:24]);
            r4_pp02  <= 22'(r_inv[19:0]) * 22'(se[69:48]);
            r4_pp10  <= 43'(r_inv[38:20]) * 43'(se[23:0]);
            r4_pp11  <= 26'(r_inv[38:20]) * 26'(se[47:24]);
            r4_pp12  <= 2'(r_inv[38:20]) * 2'(se[69:48]);
            r4_sd    <= r3_sd;
            r5_ta    <= n_ta;
            r5_tb    <= n_tb;
            r5_sd    <= r4_sd;
            r6_phase <= n_t[69 -: PHASE_BITS];
            r6_sd    <= r5_sd;
            r7_xp    <= XPW'(r6_phase[PHASE_BITS-3:0]) * XPW'(PIHALF_Q30);
            r7_sd    <= n7_sd;
            r8_x     <= n_xr[PHASE_BITS-2 +: 31];
            r8_sd    <= r7_sd;
        end
    end

    // Taylor sine and cosine
    logic        sc_v;
    logic [30:0] sc_sin, sc_cos;
    t_side       sc_sd;

    vpr_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_x     (r8_x),
        .i_side  (r8_sd),
        .o_valid (sc_v),
        .o_sin   (sc_sin),
        .o_cos   (sc_cos),
        .o_side  (sc_sd)
    );

    // Round to trig width, swap sine and cosine in quadrants 1 and 3, apply signs
    function automatic logic signed [TRIG_BITS-1:0] to_trig(input logic [30:0] v,
                                                            input logic neg);
        logic [30:0]          t;
        logic [TRIG_BITS-1:0] m;
        t = v + (31'(1) << (SH - 1));
        m = t[30:SH];
        if (neg) begin
            return $signed(-m);
        end
        return (m > TRIG_MAX) ? $signed(TRIG_MAX) : $signed(m);
    endfunction

    logic signed [TRIG_BITS-1:0] n_cs, n_sn, r_cs, r_sn;
    t_side                       r_tsd;
    logic                        r_tv;

    always_comb begin
        unique case (sc_sd.quad)
            QUAD_0: begin
                n_cs = to_trig(sc_cos, 1'b0);
                n_sn = to_trig(sc_sin, 1'b0);
            end
            QUAD_1: begin
                n_cs = to_trig(sc_sin, 1'b1);
                n_sn = to_trig(sc_cos, 1'b0);
            end
            QUAD_2: begin
                n_cs = to_trig(sc_cos, 1'b1);
                n_sn = to_trig(sc_sin, 1'b1);
            end
            QUAD_3: begin
                n_cs = to_trig(sc_sin, 1'b0);
                n_sn = to_trig(sc_cos, 1'b1);
            end
            default: begin
                n_cs = '0;
                n_sn = '0;
            end
        endcase
    end

    // Complex multiply, then round and saturate
    logic signed [PW-1:0] r_p_rc, r_p_is, r_p_rs, r_p_ic;
    logic                 r_mv, r_m_last;
    logic signed [PW:0]   n_sre, n_sim;
    logic [31:0]          n_ore, n_oim;

    function automatic logic [31:0] sat32(input logic signed [PW:0] v);
        logic signed [PW:0] s;
        s = v >>> (TRIG_BITS - 1);
        if (s[PW:31] == '0 || s[PW:31] == '1) begin
            return s[31:0];
        end
        return s[PW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    always_comb begin
        n_sre = (PW+1)'(r_p_rc) - (PW+1)'(r_p_is) + (PW+1)'(1 << (TRIG_BITS - 2));
        n_sim = (PW+1)'(r_p_rs) + (PW+1)'(r_p_ic) + (PW+1)'(1 << (TRIG_BITS - 2));
        n_ore = sat32(n_sre);
        n_oim = sat32(n_sim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv    <= 1'b0;
            r_mv    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_tv    <= sc_v;
            r_mv    <= r_tv;
            o_valid <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cs      <= n_cs;
            r_sn      <= n_sn;
            r_tsd     <= sc_sd;
            r_p_rc    <= PW'(r_tsd.re) * PW'(r_cs);
            r_p_is    <= PW'(r_tsd.im) * PW'(r_sn);
            r_p_rs    <= PW'(r_tsd.re) * PW'(r_sn);
            r_p_ic    <= PW'(r_tsd.im) * PW'(r_cs);
            r_m_last  <= r_tsd.last;
            o_rot_re  <= n_ore;
            o_rot_im  <= n_oim;
            o_end_out <= r_m_last;
        end
    end

    // Checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_trig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv |-> (r_cs != '0 || r_sn != '0))
        else $error("sine and cosine both zero");

    a_quad0_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tv && r_tsd.quad == QUAD_0) |-> (!r_cs[TRIG_BITS-1] && !r_sn[TRIG_BITS-1]))
        else $error("negative trig value in first quadrant");

endmodule
